// ===== rtl/dwss_pkg.sv =====
// ----------------------------------------------------------------------------
// dwss_pkg: shared types, constants and tables for the dual-wave synth core.
// Holds command codes, envelope stage codes, rate tables and the config map.
// ----------------------------------------------------------------------------
package dwss_pkg;

    localparam int DefaultVoices = 8;
    localparam int LevelW = 23;
    localparam int CfgW = 64;
    localparam int CfgIdxW = 3;

    typedef enum logic [2:0] {
        CMD_TICK    = 3'd0,
        CMD_NOTE_ON = 3'd1,
        CMD_NOTE_OFF = 3'd2,
        CMD_ALL_OFF = 3'd3,
        CMD_PEDAL   = 3'd4,
        CMD_REPITCH = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'd0,
        ST_ATK1 = 3'd1,
        ST_ATK2 = 3'd2,
        ST_DEC1 = 3'd3,
        ST_DEC2 = 3'd4,
        ST_REL  = 3'd5
    } env_stage_t;

    typedef enum logic [2:0] {
        REG_FLAGS   = 3'd0,
        REG_WAVE_A  = 3'd1,
        REG_WAVE_B  = 3'd2,
        REG_SUSTAIN = 3'd3,
        REG_REVERB  = 3'd4,
        REG_KEYSCL  = 3'd5,
        REG_RETRIG  = 3'd6
    } reg_idx_t;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_SCAN,
        SEQ_PICK,
        SEQ_RETRIG,
        SEQ_VOICE,
        SEQ_DONE
    } seq_state_t;

    localparam logic [LevelW-1:0] LevelMax = 23'(32'hFF << 15);
    localparam logic [LevelW-1:0] LevelLow = 23'(32'h20 << 15);
    localparam logic [LevelW-1:0] LevelAtkKnee = 23'(32'hE0 << 15);

    function automatic logic [11:0] atk1_rate(input logic [2:0] c);
        case (c)
            3'd1: atk1_rate = 12'd2048;
            3'd2: atk1_rate = 12'd512;
            3'd3: atk1_rate = 12'd256;
            3'd4: atk1_rate = 12'd160;
            3'd5: atk1_rate = 12'd80;
            3'd6: atk1_rate = 12'd32;
            3'd7: atk1_rate = 12'd8;
            default: atk1_rate = 12'd0;
        endcase
    endfunction

    function automatic logic [11:0] atk2_rate(input logic [2:0] c);
        case (c)
            3'd1: atk2_rate = 12'd2048;
            3'd2: atk2_rate = 12'd256;
            3'd3: atk2_rate = 12'd128;
            3'd4: atk2_rate = 12'd64;
            3'd5: atk2_rate = 12'd32;
            3'd6: atk2_rate = 12'd16;
            3'd7: atk2_rate = 12'd8;
            default: atk2_rate = 12'd0;
        endcase
    endfunction

    function automatic logic [11:0] dec1_rate(input logic [2:0] c);
        case (c)
            3'd0: dec1_rate = 12'd2048;
            3'd1: dec1_rate = 12'd640;
            3'd2: dec1_rate = 12'd160;
            3'd3: dec1_rate = 12'd32;
            3'd4: dec1_rate = 12'd16;
            3'd5: dec1_rate = 12'd8;
            3'd6: dec1_rate = 12'd2;
            default: dec1_rate = 12'd0;
        endcase
    endfunction

    function automatic logic [3:0] step_mag(input logic [2:0] c);
        case (c)
            3'd1: step_mag = 4'd1;
            3'd2, 3'd3: step_mag = 4'd2;
            3'd4, 3'd5: step_mag = 4'd4;
            3'd6, 3'd7: step_mag = 4'd8;
            default: step_mag = 4'd0;
        endcase
    endfunction

    function automatic logic [3:0] cyc_mask(input logic [1:0] m);
        case (m)
            2'd0: cyc_mask = 4'hF;
            2'd1: cyc_mask = 4'h5;
            2'd2: cyc_mask = 4'h1;
            default: cyc_mask = 4'h3;
        endcase
    endfunction

    typedef struct packed {
        logic [25:0] flags;
        logic [63:0] wave_a;
        logic [63:0] wave_b;
        logic [1:0]  sustain;
        logic        reverb;
    } dwss_cfg_t;

endpackage

// ===== rtl/dwss_cmd_if.sv =====
// ----------------------------------------------------------------------------
// dwss_cmd_if: command channel with valid/ready handshake.
// Carries the command code, note, velocity and pitch step.
// ----------------------------------------------------------------------------
interface dwss_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [6:0]  note;
    logic [6:0]  velocity;
    logic [15:0] pitch_step;

    modport source (output valid, cmd, note, velocity, pitch_step, input ready);
    modport sink (input valid, cmd, note, velocity, pitch_step, output ready);
endinterface

// ===== rtl/dwss_out_if.sv =====
// ----------------------------------------------------------------------------
// dwss_out_if: result channel with valid/ready handshake.
// Carries the mixed sample and the active voice mask.
// ----------------------------------------------------------------------------
interface dwss_out_if;
    logic               valid;
    logic               ready;
    logic signed [17:0] sample;
    logic [7:0]         active_mask;

    modport source (output valid, sample, active_mask, input ready);
    modport sink (input valid, sample, active_mask, output ready);
endinterface

// ===== rtl/dwss_voice_unit.sv =====
// ----------------------------------------------------------------------------
// dwss_voice_unit: shared envelope and wave step unit.
// Computes one voice's next state and its contribution to the mix.
// ----------------------------------------------------------------------------
module dwss_voice_unit (
    input  dwss_pkg::dwss_cfg_t      cfg,
    input  logic [2:0]               stage_in,
    input  logic [22:0]              count_in,
    input  logic [22:0]              lvl_a_in,
    input  logic [22:0]              lvl_b_in,
    input  logic                     fast_in,
    input  logic [15:0]              pitch_in,
    input  logic [20:0]              phase_in,
    input  logic signed [2:0]        ts_in,
    input  logic [3:0]               lastpos_in,
    input  logic                     posv_in,
    input  logic [5:0]               acc_a_in,
    input  logic [5:0]               acc_b_in,
    output logic [2:0]               stage_out,
    output logic [22:0]              count_out,
    output logic [22:0]              lvl_a_out,
    output logic [22:0]              lvl_b_out,
    output logic [20:0]              phase_out,
    output logic [3:0]               lastpos_out,
    output logic                     posv_out,
    output logic [5:0]               acc_a_out,
    output logic [5:0]               acc_b_out,
    output logic signed [17:0]       contrib
);
    import dwss_pkg::*;

    logic [1:0]  sh;
    logic [23:0] rate;
    logic [23:0] sum;
    logic [22:0] cnt_sat;
    logic [22:0] drate;
    logic        dec_under;
    logic [22:0] dec_val;
    logic [6:0]  pos_full;
    logic [3:0]  pos;
    logic [1:0]  cyc;
    logic        take;
    logic [3:0]  code_a;
    logic [3:0]  code_b;
    logic [5:0]  step_a;
    logic [5:0]  step_b;
    logic [3:0]  pw;
    logic [3:0]  cmask_a;
    logic [3:0]  cmask_b;
    logic signed [14:0] prod_a;
    logic signed [14:0] prod_b;

    function automatic logic [5:0] signed_step(input logic [3:0] c, input logic inv);
        logic [5:0] m;
        m = {2'd0, step_mag(c[2:0])};
        signed_step = (c[3] ^ inv) ? 6'(-m) : m;
    endfunction

    assign sh = cfg.flags[17:16];

    always_comb
    begin
        rate = '0;
        drate = '0;
        case (stage_in)
            ST_ATK1:
            begin
                if (cfg.flags[8:6] == 3'd0)
                    rate = {1'b0, LevelMax};
                else if (cfg.flags[8:6] < 3'd4 && count_in >= LevelAtkKnee)
                    rate = 24'(24'd160 << sh);
                else
                    rate = 24'({12'd0, atk1_rate(cfg.flags[8:6])} << sh);
            end
            ST_ATK2:
            begin
                if (cfg.flags[5:3] == 3'd0)
                    rate = {1'b0, LevelMax};
                else
                    rate = 24'({12'd0, atk2_rate(cfg.flags[5:3])} << sh);
            end
            ST_DEC1:
                drate = 23'({11'd0, dec1_rate(cfg.flags[2:0])} << sh);
            ST_DEC2:
            begin
                if (cfg.reverb && count_in < LevelLow)
                    drate = 23'(23'd1 << sh);
                else
                    drate = 23'((cfg.flags[10] ? 23'd3 : 23'd6) << sh);
            end
            ST_REL:
            begin
                drate = 23'(23'd512 << sh);
                if (!fast_in)
                begin
                    if (cfg.reverb && count_in < LevelLow)
                        drate = 23'(23'd1 << sh);
                    else if (cfg.sustain == 2'd1)
                        drate = 23'(23'd16 << sh);
                    else if (cfg.sustain == 2'd2)
                        drate = 23'(23'd12 << sh);
                end
            end
            default:
                rate = '0;
        endcase
    end

    assign sum = {1'b0, count_in} + rate;
    assign cnt_sat = (sum > {1'b0, LevelMax}) ? LevelMax : sum[22:0];
    assign dec_under = count_in < drate;
    assign dec_val = dec_under ? '0 : count_in - drate;

    always_comb
    begin
        stage_out = stage_in;
        count_out = count_in;
        lvl_a_out = lvl_a_in;
        lvl_b_out = lvl_b_in;
        case (stage_in)
            ST_ATK1:
            begin
                lvl_a_out = cfg.flags[14] ? '0 : cnt_sat;
                lvl_b_out = cnt_sat;
                count_out = cnt_sat;
                if (cnt_sat >= LevelMax)
                begin
                    count_out = '0;
                    stage_out = ST_ATK2;
                end
            end
            ST_ATK2:
            begin
                count_out = cnt_sat;
                if (cfg.flags[14])
                    lvl_a_out = cnt_sat;
                if (cfg.flags[13])
                    lvl_b_out = LevelMax - cnt_sat;
                if (cnt_sat >= LevelMax)
                    stage_out = ST_DEC1;
            end
            ST_DEC1, ST_DEC2:
            begin
                count_out = dec_val;
                if (dec_under)
                    stage_out = ST_IDLE;
                lvl_a_out = dec_val;
                if (lvl_b_in != '0)
                    lvl_b_out = dec_val;
                if (stage_in == ST_DEC1 && !cfg.flags[15])
                begin
                    if (dec_val < (cfg.flags[9] ? 23'(32'h40 << 15) : 23'(32'h80 << 15)))
                        stage_out = ST_DEC2;
                end
            end
            ST_REL:
            begin
                count_out = dec_val;
                if (dec_under)
                    stage_out = ST_IDLE;
                lvl_a_out = (lvl_a_in < dec_val) ? lvl_a_in : dec_val;
                lvl_b_out = (lvl_b_in < dec_val) ? lvl_b_in : dec_val;
            end
            default:
                stage_out = stage_in;
        endcase
    end

    // Wave step: the timbre value picks where the table position sits in the
    // phase and how wide it is. Positions of 16 and above are skipped.
    assign phase_out = phase_in + 21'(pitch_in);
    assign cyc = phase_out[20:19];
    always_comb
    begin
        case (ts_in)
            -3'sd1:  pos_full = {4'd0, phase_out[18:16]};
            3'sd0:   pos_full = {3'd0, phase_out[18:15]};
            3'sd1:   pos_full = {2'd0, phase_out[18:14]};
            3'sd2:   pos_full = {1'b0, phase_out[18:13]};
            3'sd3:   pos_full = phase_out[18:12];
            default: pos_full = {5'd0, phase_out[18:17]};
        endcase
    end
    assign take = !(pos_full >= 7'd16) && !(posv_in && pos_full[3:0] == lastpos_in);
    assign pw = pos_full[3:0];
    assign pos = (cfg.flags[19] && cyc[0]) ? ~pw : pw;
    assign code_a = cfg.wave_a[{pos, 2'b00} +: 4];
    assign code_b = cfg.wave_b[{pos, 2'b00} +: 4];

    assign step_a = signed_step(code_a, cfg.flags[20] && cyc[0]);
    assign step_b = signed_step(code_b, cfg.flags[20] && cyc[0]);
    assign cmask_a = cyc_mask(cfg.flags[24:23]);
    assign cmask_b = cyc_mask(cfg.flags[22:21]);

    always_comb
    begin
        lastpos_out = lastpos_in;
        posv_out = posv_in;
        acc_a_out = acc_a_in;
        acc_b_out = acc_b_in;
        if (take)
        begin
            lastpos_out = pw;
            posv_out = 1'b1;
            if (cmask_a[cyc])
                acc_a_out = acc_a_in + step_a;
            if (cmask_b[cyc])
                acc_b_out = acc_b_in + step_b;
        end
    end

    assign prod_a = $signed(acc_a_out) * $signed({1'b0, lvl_a_out[22:15]});
    assign prod_b = $signed(acc_b_out) * $signed({1'b0, lvl_b_out[22:15]});
    assign contrib = 18'(prod_a) + 18'(prod_b);

endmodule

// ===== rtl/dual_wave_step_synth_voices_core.sv =====
// ----------------------------------------------------------------------------
// dual_wave_step_synth_voices_core: eight-voice dual-wave step synth core.
// Command in, sample mix out, with one shared voice unit under a sequencer.
// ----------------------------------------------------------------------------
// Usage: commands arrive as transactions on cmd_in. A sample tick produces
// one transaction on res_out carrying the mixed sample and the mask of voices
// still sounding; every other command produces nothing. Configuration is to be
// written through cfg_we/cfg_index/cfg_data while the core is idle; the
// core itself does not enforce this. Timing: a tick runs a retrigger step,
// then steps the voices one at a time through the shared envelope/wave unit;
// the last voice step loads the output register. The core is ready again
// after that, so a new command is accepted only once the tick is through. A
// note on with nonzero velocity scans the voices one per cycle for the voice
// pick, then writes the picked voice; other commands pass one done state.
// Reset clears every voice, the registers and the retrigger counter; the core
// comes out of reset ready. When the receiver stalls, the result is held in
// the output register; commands are still accepted, and a following tick
// waits before its last voice step until the output register is free.
// ----------------------------------------------------------------------------
module dual_wave_step_synth_voices_core #(
    parameter int VOICES = dwss_pkg::DefaultVoices
) (
    input  logic                            clk,
    input  logic                            rst_n,
    dwss_cmd_if.sink                        cmd_in,
    dwss_out_if.source                      res_out,
    input  logic                            cfg_we,
    input  logic [dwss_pkg::CfgIdxW-1:0]    cfg_index,
    input  logic [dwss_pkg::CfgW-1:0]       cfg_data
);
    import dwss_pkg::*;

    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
    // The index is at least four bits so the eight mask positions can be
    // addressed for any voice count.
    localparam int CW = ($clog2(VOICES + 1) > 3) ? $clog2(VOICES + 1) : 4;

    // Configuration registers.
    dwss_cfg_t   cfg_reg;
    logic        keyscl_reg;
    logic [15:0] retrig_period_reg;
    logic [15:0] retrig_count_reg;

    // Per-voice state, one flop set per voice.
    logic [6:0]        note_reg   [VOICES];
    logic              active_reg [VOICES];
    logic [15:0]       pitch_reg  [VOICES];
    logic [20:0]       phase_reg  [VOICES];
    logic signed [2:0] ts_reg     [VOICES];
    logic [3:0]        lastpos_reg[VOICES];
    logic              posv_reg   [VOICES];
    logic [5:0]        acca_reg   [VOICES];
    logic [5:0]        accb_reg   [VOICES];
    logic [2:0]        stage_reg  [VOICES];
    logic [22:0]       count_reg  [VOICES];
    logic [22:0]       lvla_reg   [VOICES];
    logic [22:0]       lvlb_reg   [VOICES];
    logic              fast_reg   [VOICES];

    // Sequencer.
    seq_state_t state_reg, state_next;
    logic [CW-1:0] idx_reg;
    logic [2:0]    cmd_reg;
    logic [6:0]    cnote_reg;
    logic [15:0]   cpitch_reg;
    logic signed [17:0] sum_reg;
    logic [7:0]    mask_reg;
    logic          out_valid_reg;
    logic signed [17:0] out_sample_reg;
    logic [7:0]    out_mask_reg;

    // Voice pick scan: best candidate per priority class.
    logic          f_same_reg, f_free_reg, f_rel_reg;
    logic [VW-1:0] v_same_reg, v_free_reg, v_rel_reg, v_min_reg;
    logic [23:0]   min_lvl_reg;

    logic [VW-1:0] vi;
    logic          in_fire;
    logic [VW-1:0] pick;

    assign vi = idx_reg[VW-1:0];
    assign in_fire = cmd_in.valid && cmd_in.ready;
    assign cmd_in.ready = (state_reg == SEQ_IDLE);
    assign res_out.valid = out_valid_reg;
    assign res_out.sample = out_sample_reg;
    assign res_out.active_mask = out_mask_reg;

    always_comb
    begin
        if (f_same_reg)
            pick = v_same_reg;
        else if (f_free_reg)
            pick = v_free_reg;
        else if (f_rel_reg)
            pick = v_rel_reg;
        else
            pick = v_min_reg;
    end

    // Shared voice unit, fed from the voice selected by the sequencer index.
    logic [2:0]  u_stage;
    logic [22:0] u_count, u_lvla, u_lvlb;
    logic [20:0] u_phase;
    logic [3:0]  u_lastpos;
    logic        u_posv;
    logic [5:0]  u_acca, u_accb;
    logic signed [17:0] u_contrib;

    dwss_voice_unit u_voice (
        .cfg        (cfg_reg),
        .stage_in   (stage_reg[vi]),
        .count_in   (count_reg[vi]),
        .lvl_a_in   (lvla_reg[vi]),
        .lvl_b_in   (lvlb_reg[vi]),
        .fast_in    (fast_reg[vi]),
        .pitch_in   (pitch_reg[vi]),
        .phase_in   (phase_reg[vi]),
        .ts_in      (ts_reg[vi]),
        .lastpos_in (lastpos_reg[vi]),
        .posv_in    (posv_reg[vi]),
        .acc_a_in   (acca_reg[vi]),
        .acc_b_in   (accb_reg[vi]),
        .stage_out  (u_stage),
        .count_out  (u_count),
        .lvl_a_out  (u_lvla),
        .lvl_b_out  (u_lvlb),
        .phase_out  (u_phase),
        .lastpos_out(u_lastpos),
        .posv_out   (u_posv),
        .acc_a_out  (u_acca),
        .acc_b_out  (u_accb),
        .contrib    (u_contrib)
    );

    logic last_idx;
    assign last_idx = (idx_reg == CW'(VOICES - 1));

    // The output register can take a new result when it is empty or when its
    // current result leaves in this cycle.
    logic out_free;
    logic res_load;
    assign out_free = !out_valid_reg || res_out.ready;
    assign res_load = (state_reg == SEQ_VOICE) && last_idx && out_free;

    // Running sum and mask including the voice handled in this cycle.
    logic signed [17:0] sum_now;
    logic [7:0]         mask_now;
    assign sum_now = active_reg[vi] ? sum_reg + u_contrib : sum_reg;
    assign mask_now = (active_reg[vi] && u_stage != ST_IDLE && idx_reg < CW'(8)) ?
                      (mask_reg | 8'(8'd1 << idx_reg[2:0])) : mask_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SEQ_IDLE:
            begin
                if (in_fire)
                begin
                    if (cmd_in.cmd == CMD_TICK)
                        state_next = SEQ_RETRIG;
                    else if (cmd_in.cmd == CMD_NOTE_ON && cmd_in.velocity != 7'd0)
                        state_next = SEQ_SCAN;
                    else
                        state_next = SEQ_DONE;
                end
            end
            SEQ_SCAN:   state_next = last_idx ? SEQ_PICK : SEQ_SCAN;
            SEQ_PICK:   state_next = SEQ_IDLE;
            SEQ_RETRIG: state_next = SEQ_VOICE;
            SEQ_VOICE:  state_next = (last_idx && out_free) ? SEQ_IDLE : SEQ_VOICE;
            SEQ_DONE:   state_next = SEQ_IDLE;
            default:    state_next = SEQ_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= SEQ_IDLE;
        else
            state_reg <= state_next;
    end

    // Key scaling: the octave of the note, counted in steps of twelve notes
    // and clamped, gives the timbre shift.
    logic signed [2:0] new_ts;
    always_comb
    begin
        if (!keyscl_reg)
            new_ts = 3'sd0;
        else if (cnote_reg < 7'd36)
            new_ts = 3'sd3;
        else if (cnote_reg < 7'd48)
            new_ts = 3'sd2;
        else if (cnote_reg < 7'd60)
            new_ts = 3'sd1;
        else if (cnote_reg < 7'd72)
            new_ts = 3'sd0;
        else if (cnote_reg < 7'd84)
            new_ts = -3'sd1;
        else
            new_ts = -3'sd2;
    end

    logic [16:0] retrig_next;
    logic        retrig_fire;
    assign retrig_next = {1'b0, retrig_count_reg} + 17'd1;
    assign retrig_fire = cfg_reg.flags[11] && retrig_period_reg != 16'd0 &&
                         retrig_next >= {1'b0, retrig_period_reg};

    logic [23:0] lvl_sum;
    assign lvl_sum = {1'b0, lvla_reg[vi]} + {1'b0, lvlb_reg[vi]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
            keyscl_reg <= 1'b0;
            retrig_period_reg <= '0;
            retrig_count_reg <= '0;
            idx_reg <= '0;
            out_valid_reg <= 1'b0;
            out_sample_reg <= '0;
            out_mask_reg <= '0;
            cmd_reg <= '0;
            cnote_reg <= '0;
            cpitch_reg <= '0;
            sum_reg <= '0;
            mask_reg <= '0;
            f_same_reg <= 1'b0;
            f_free_reg <= 1'b0;
            f_rel_reg <= 1'b0;
            v_same_reg <= '0;
            v_free_reg <= '0;
            v_rel_reg <= '0;
            v_min_reg <= '0;
            min_lvl_reg <= '1;
            for (int i = 0; i < VOICES; i++)
            begin
                note_reg[i] <= '0;
                active_reg[i] <= 1'b0;
                pitch_reg[i] <= '0;
                phase_reg[i] <= '0;
                ts_reg[i] <= '0;
                lastpos_reg[i] <= '0;
                posv_reg[i] <= 1'b0;
                acca_reg[i] <= '0;
                accb_reg[i] <= '0;
                stage_reg[i] <= ST_IDLE;
                count_reg[i] <= '0;
                lvla_reg[i] <= '0;
                lvlb_reg[i] <= '0;
                fast_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_FLAGS:   cfg_reg.flags <= cfg_data[25:0];
                    REG_WAVE_A:  cfg_reg.wave_a <= cfg_data;
                    REG_WAVE_B:  cfg_reg.wave_b <= cfg_data;
                    REG_SUSTAIN: cfg_reg.sustain <= cfg_data[1:0];
                    REG_REVERB:  cfg_reg.reverb <= cfg_data[0];
                    REG_KEYSCL:  keyscl_reg <= cfg_data[0];
                    REG_RETRIG:  retrig_period_reg <= cfg_data[15:0];
                    default:     keyscl_reg <= keyscl_reg;
                endcase
            end

            if (res_load)
            begin
                out_valid_reg <= 1'b1;
                out_sample_reg <= sum_now;
                out_mask_reg <= mask_now;
            end
            else if (res_out.valid && res_out.ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                SEQ_IDLE:
                begin
                    idx_reg <= '0;
                    if (in_fire)
                    begin
                        cmd_reg <= cmd_in.cmd;
                        cnote_reg <= cmd_in.note;
                        cpitch_reg <= cmd_in.pitch_step;
                        sum_reg <= '0;
                        mask_reg <= '0;
                        f_same_reg <= 1'b0;
                        f_free_reg <= 1'b0;
                        f_rel_reg <= 1'b0;
                        v_same_reg <= '0;
                        v_free_reg <= '0;
                        v_rel_reg <= '0;
                        v_min_reg <= '0;
                        min_lvl_reg <= '1;
                    end
                end
                SEQ_SCAN:
                begin
                    if (!f_same_reg && active_reg[vi] && note_reg[vi] == cnote_reg)
                    begin
                        f_same_reg <= 1'b1;
                        v_same_reg <= vi;
                    end
                    if (!f_free_reg && !active_reg[vi])
                    begin
                        f_free_reg <= 1'b1;
                        v_free_reg <= vi;
                    end
                    if (!f_rel_reg && stage_reg[vi] == ST_REL)
                    begin
                        f_rel_reg <= 1'b1;
                        v_rel_reg <= vi;
                    end
                    if (lvl_sum < min_lvl_reg)
                    begin
                        min_lvl_reg <= lvl_sum;
                        v_min_reg <= vi;
                    end
                    idx_reg <= idx_reg + CW'(1);
                end
                SEQ_PICK:
                begin
                    note_reg[pick] <= cnote_reg;
                    active_reg[pick] <= 1'b1;
                    pitch_reg[pick] <= cpitch_reg;
                    ts_reg[pick] <= new_ts;
                    phase_reg[pick] <= '0;
                    posv_reg[pick] <= 1'b0;
                    lastpos_reg[pick] <= '0;
                    acca_reg[pick] <= '0;
                    accb_reg[pick] <= '0;
                    stage_reg[pick] <= ST_ATK1;
                    count_reg[pick] <= '0;
                    lvla_reg[pick] <= '0;
                    lvlb_reg[pick] <= '0;
                    fast_reg[pick] <= 1'b0;
                    retrig_count_reg <= '0;
                end
                SEQ_RETRIG:
                begin
                    if (cfg_reg.flags[11] && retrig_period_reg != 16'd0)
                    begin
                        if (retrig_fire)
                        begin
                            retrig_count_reg <= '0;
                            for (int i = 0; i < VOICES; i++)
                            begin
                                if (stage_reg[i] == ST_DEC1 || stage_reg[i] == ST_DEC2)
                                begin
                                    stage_reg[i] <= ST_ATK1;
                                    count_reg[i] <= '0;
                                end
                            end
                        end
                        else
                            retrig_count_reg <= retrig_next[15:0];
                    end
                end
                SEQ_VOICE:
                begin
                    // The last voice waits here while the previous result is
                    // still held in the output register.
                    if (!last_idx || out_free)
                    begin
                        if (active_reg[vi])
                        begin
                            stage_reg[vi] <= u_stage;
                            count_reg[vi] <= u_count;
                            lvla_reg[vi] <= u_lvla;
                            lvlb_reg[vi] <= u_lvlb;
                            phase_reg[vi] <= u_phase;
                            lastpos_reg[vi] <= u_lastpos;
                            posv_reg[vi] <= u_posv;
                            acca_reg[vi] <= u_acca;
                            accb_reg[vi] <= u_accb;
                            if (u_stage == ST_IDLE)
                                active_reg[vi] <= 1'b0;
                        end
                        sum_reg <= sum_now;
                        mask_reg <= mask_now;
                        idx_reg <= idx_reg + CW'(1);
                    end
                end
                SEQ_DONE:
                begin
                    for (int i = 0; i < VOICES; i++)
                    begin
                        case (cmd_reg)
                            CMD_NOTE_ON, CMD_NOTE_OFF:
                            begin
                                if (active_reg[i] && note_reg[i] == cnote_reg)
                                begin
                                    stage_reg[i] <= ST_REL;
                                    fast_reg[i] <= 1'b0;
                                end
                            end
                            CMD_ALL_OFF:
                            begin
                                if (active_reg[i])
                                begin
                                    stage_reg[i] <= ST_REL;
                                    fast_reg[i] <= 1'b1;
                                end
                            end
                            CMD_PEDAL:
                            begin
                                if (active_reg[i] &&
                                    (stage_reg[i] == ST_DEC1 || stage_reg[i] == ST_DEC2))
                                    stage_reg[i] <= ST_REL;
                            end
                            CMD_REPITCH:
                            begin
                                if (active_reg[i] && note_reg[i] == cnote_reg)
                                    pitch_reg[i] <= cpitch_reg;
                            end
                            default:
                                fast_reg[i] <= fast_reg[i];
                        endcase
                    end
                end
                default:
                    idx_reg <= '0;
            endcase
        end
    end

endmodule
